### rtl/core/point_plane_distance_macros.svh
`ifndef POINT_PLANE_DISTANCE_MACROS_SVH
`define POINT_PLANE_DISTANCE_MACROS_SVH

// same-cycle implication, checked on clk, off while in reset
`define PPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ppd_pkg.sv
package ppd_pkg;

	localparam int COORD_W    = 20;
	localparam int VERTEX_W   = 3 * COORD_W;
	localparam int EDGE_W     = COORD_W + 1;
	localparam int MAG_W      = 2 * EDGE_W - 1;
	localparam int NDIFF_W    = MAG_W + 1;
	localparam int NORM_W     = 30;
	localparam int MUL_W      = NORM_W + 1;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int SUM_W      = 2 * NORM_W + 2;
	localparam int ACC_W      = SUM_W + 1;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int QUOT_W     = 16;
	localparam int FRAC_SHIFT = 15;
	localparam int NUM_W      = NORM_W + FRAC_SHIFT + 1;
	localparam int UNIT_W     = QUOT_W + 1;
	localparam int DOT_W      = 40;
	localparam int DIST_W     = 22;
	localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
	localparam int CFG_IDX_W  = 2;
	localparam int INDEX_BITS_DEF = 10;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} ppd_unit_sts_t;

	function automatic logic signed [COORD_W-1:0] coord(input logic [VERTEX_W-1:0] v,
		input int k);
		return $signed(v[k*COORD_W +: COORD_W]);
	endfunction

endpackage

### rtl/core/ppd_mul.sv
module ppd_mul (
	input  logic                                clk,
	input  logic signed [ppd_pkg::MUL_W-1:0]    a,
	input  logic signed [ppd_pkg::MUL_W-1:0]    b,
	output logic signed [ppd_pkg::PROD_W-1:0]   prod
);
	import ppd_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

### rtl/core/ppd_isqrt.sv
module ppd_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ppd_pkg::SUM_W-1:0]      radicand,
	output logic [ppd_pkg::ROOT_W-1:0]     root,
	output ppd_pkg::ppd_unit_sts_t         sts
);
	import ppd_pkg::*;

	localparam logic [SUM_W-1:0] BIT_START = SUM_W'(1) << (SUM_W - 2);

	logic             busy_q, done_q;
	logic [SUM_W-1:0] v_q, res_q, bit_q;
	logic [SUM_W:0]   trial;
	logic             take;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, v_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q & bit_q[0];
			if (start)
				busy_q <= 1'b1;
			else if (bit_q[0])
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= BIT_START;
		end else if (busy_q) begin
			if (take) begin
				v_q   <= v_q - trial[SUM_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root     = res_q[ROOT_W-1:0];
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

### rtl/core/ppd_div.sv
module ppd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ppd_pkg::NUM_W-1:0]      numer,
	input  logic [ppd_pkg::ROOT_W-1:0]     denom,
	output logic [ppd_pkg::QUOT_W-1:0]     quot,
	output ppd_pkg::ppd_unit_sts_t         sts
);
	import ppd_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROOT_W-1:0] rem_q, den_q;
	logic [QUOT_W-1:0] low_q, quot_q;
	logic [ROOT_W:0]   trial, diff;
	logic              ge;

	// quotient fits QUOT_W bits, so the upper numerator bits start below denom
	assign trial = {rem_q, low_q[QUOT_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(numer[NUM_W-1:QUOT_W]);
			low_q <= numer[QUOT_W-1:0];
			den_q <= denom;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
			low_q  <= low_q << 1;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign quot     = quot_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

### rtl/core/point_plane_distance.sv
// Signed distance of points from the plane of triangle A, B, C (vertex
// registers, three Q12.8 coordinates each). One point is in work at a time;
// in_ready is high only while idle. With the unit normal cached, a point's
// distance is three products on the single shared 31x31 multiplier,
// accumulated, then rounded and saturated. The first point after reset or
// after any vertex write first builds the normal on the same multiplier plus
// a bit-pair square root (31 steps) and a radix-2 divider (16 steps per
// component). A finished result waits in the output register and a new
// point may be accepted meanwhile.
`include "point_plane_distance_macros.svh"

module point_plane_distance #(
	parameter int INDEX_BITS = ppd_pkg::INDEX_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ppd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ppd_pkg::VERTEX_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [INDEX_BITS-1:0]                point_index,
	input  logic signed [ppd_pkg::COORD_W-1:0]   point_x,
	input  logic signed [ppd_pkg::COORD_W-1:0]   point_y,
	input  logic signed [ppd_pkg::COORD_W-1:0]   point_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [INDEX_BITS-1:0]                result_index,
	output logic signed [ppd_pkg::DIST_W-1:0]    signed_distance,
	output logic                                 degenerate_face
);
	import ppd_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_EDGE   = 4'd1;
	localparam logic [3:0] ST_CROSS  = 4'd2;
	localparam logic [3:0] ST_NORM   = 4'd3;
	localparam logic [3:0] ST_SQ     = 4'd4;
	localparam logic [3:0] ST_SQRT   = 4'd5;
	localparam logic [3:0] ST_DIVGO  = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_DIST   = 4'd8;
	localparam logic [3:0] ST_FINISH = 4'd9;

	localparam int SH_W = DOT_W - FRAC_SHIFT;

	logic [3:0]                state_q;
	logic [2:0]                step_q;
	logic [1:0]                comp_q;
	logic [VERTEX_W-1:0]       vtx_q [3];
	logic                      normal_ready_q, deg_q;
	logic [INDEX_BITS-1:0]     idx_q;
	logic signed [EDGE_W-1:0]  pa_q [3];
	logic signed [EDGE_W-1:0]  e1_q [3];
	logic signed [EDGE_W-1:0]  e2_q [3];
	logic [MAG_W-1:0]          mag_q [3];
	logic [2:0]                neg_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ROOT_W-1:0]         len_q;
	logic signed [UNIT_W-1:0]  unit_q [3];

	logic                      out_valid_q, out_deg_q;
	logic [INDEX_BITS-1:0]     out_idx_q;
	logic [DIST_W-1:0]         out_dist_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic                      sqrt_start, div_start;
	logic [ROOT_W-1:0]         root;
	logic [QUOT_W-1:0]         quot;
	logic [NUM_W-1:0]          numer;
	ppd_unit_sts_t             sqrt_sts, div_sts;

	logic signed [NDIFF_W-1:0] cross_diff, cross_abs;
	logic [1:0]                cross_sel;
	logic                      mag_hi, mag_top, mag_zero;
	logic signed [DOT_W-1:0]   dot_rnd;
	logic [SH_W-1:0]           dot_sh;
	logic                      dot_ovf;
	logic [DIST_W-1:0]         dist_sat;
	logic signed [UNIT_W-1:0]  unit_pos;
	logic                      out_load;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_CROSS: begin
				case (step_q)
					3'd0: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
					3'd1: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
					3'd2: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
					3'd3: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
					3'd4: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
					3'd5: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
					default: ;
				endcase
			end
			ST_SQ: begin
				if (step_q < 3'd3) begin
					mul_a = $signed({1'b0, mag_q[step_q[1:0]][NORM_W-1:0]});
					mul_b = $signed({1'b0, mag_q[step_q[1:0]][NORM_W-1:0]});
				end
			end
			ST_DIST: begin
				if (step_q < 3'd3) begin
					mul_a = MUL_W'(unit_q[step_q[1:0]]);
					mul_b = MUL_W'(pa_q[step_q[1:0]]);
				end
			end
			default: ;
		endcase
	end

	ppd_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign sqrt_start = (state_q == ST_SQ) && (step_q == 3'd4);
	assign div_start  = (state_q == ST_DIVGO);
	assign numer      = NUM_W'({mag_q[comp_q][NORM_W-1:0], {FRAC_SHIFT{1'b0}}})
		+ NUM_W'(len_q >> 1);

	ppd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_q[SUM_W-1:0]),
		.root     (root),
		.sts      (sqrt_sts)
	);

	ppd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numer),
		.denom  (len_q),
		.quot   (quot),
		.sts    (div_sts)
	);

	assign cross_diff = $signed(acc_q[NDIFF_W-1:0]) - $signed(prod[NDIFF_W-1:0]);
	assign cross_abs  = cross_diff[NDIFF_W-1] ? -cross_diff : cross_diff;
	assign cross_sel  = step_q[2:1] - 2'd1;

	assign mag_hi   = |{mag_q[0][MAG_W-1:NORM_W], mag_q[1][MAG_W-1:NORM_W],
		mag_q[2][MAG_W-1:NORM_W]};
	assign mag_top  = |{mag_q[0][MAG_W-1:NORM_W-1], mag_q[1][MAG_W-1:NORM_W-1],
		mag_q[2][MAG_W-1:NORM_W-1]};
	assign mag_zero = ~|{mag_q[0], mag_q[1], mag_q[2]};

	assign unit_pos = $signed({1'b0, quot});

	// round half up in Q.23 then floor to Q14.8, saturate to DIST_W
	assign dot_rnd  = $signed(acc_q[DOT_W-1:0]) + DOT_W'(ROUND_HALF);
	assign dot_sh   = dot_rnd[DOT_W-1:FRAC_SHIFT];
	assign dot_ovf  = dot_sh[SH_W-1:DIST_W-1] != {(SH_W-DIST_W+1){dot_sh[SH_W-1]}};
	assign dist_sat = !dot_ovf ? dot_sh[DIST_W-1:0]
		: dot_sh[SH_W-1] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};

	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			comp_q         <= '0;
			normal_ready_q <= 1'b0;
			deg_q          <= 1'b0;
			out_valid_q    <= 1'b0;
			for (int i = 0; i < 3; i++)
				vtx_q[i] <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_VERTEX_A, REG_VERTEX_B, REG_VERTEX_C: begin
						vtx_q[cfg_index] <= cfg_data;
						normal_ready_q   <= 1'b0;
					end
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q <= '0;
						if (!normal_ready_q)
							state_q <= ST_EDGE;
						else if (deg_q)
							state_q <= ST_FINISH;
						else
							state_q <= ST_DIST;
					end
				end
				ST_EDGE: begin
					step_q  <= '0;
					state_q <= ST_CROSS;
				end
				ST_CROSS: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6)
						state_q <= ST_NORM;
				end
				ST_NORM: begin
					step_q <= '0;
					if (mag_zero) begin
						deg_q          <= 1'b1;
						normal_ready_q <= 1'b1;
						state_q        <= ST_FINISH;
					end else if (!mag_hi && mag_top) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4)
						state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					comp_q <= '0;
					if (sqrt_sts.done)
						state_q <= ST_DIVGO;
				end
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_sts.done) begin
						if (comp_q == 2'd2) begin
							normal_ready_q <= 1'b1;
							deg_q          <= 1'b0;
							step_q         <= '0;
							state_q        <= ST_DIST;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= ST_DIVGO;
						end
					end
				end
				ST_DIST: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q   <= point_index;
				acc_q   <= '0;
				pa_q[0] <= EDGE_W'(point_x) - EDGE_W'(coord(vtx_q[REG_VERTEX_A], 0));
				pa_q[1] <= EDGE_W'(point_y) - EDGE_W'(coord(vtx_q[REG_VERTEX_A], 1));
				pa_q[2] <= EDGE_W'(point_z) - EDGE_W'(coord(vtx_q[REG_VERTEX_A], 2));
			end
			ST_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= EDGE_W'(coord(vtx_q[REG_VERTEX_B], i))
						- EDGE_W'(coord(vtx_q[REG_VERTEX_A], i));
					e2_q[i] <= EDGE_W'(coord(vtx_q[REG_VERTEX_C], i))
						- EDGE_W'(coord(vtx_q[REG_VERTEX_A], i));
				end
			end
			ST_CROSS: begin
				if (step_q != 3'd0) begin
					if (step_q[0]) begin
						acc_q <= ACC_W'(prod);
					end else begin
						mag_q[cross_sel] <= cross_abs[MAG_W-1:0];
						neg_q[cross_sel] <= cross_diff[NDIFF_W-1];
					end
				end
			end
			ST_NORM: begin
				acc_q <= '0;
				for (int i = 0; i < 3; i++) begin
					if (mag_zero)
						unit_q[i] <= '0;
					else if (mag_hi)
						mag_q[i] <= mag_q[i] >> 1;
					else if (!mag_top)
						mag_q[i] <= mag_q[i] << 1;
				end
			end
			ST_SQ: begin
				if (step_q != 3'd0)
					acc_q <= acc_q + ACC_W'(prod);
			end
			ST_SQRT: begin
				if (sqrt_sts.done)
					len_q <= root;
			end
			ST_DIV: begin
				acc_q <= '0;
				if (div_sts.done)
					unit_q[comp_q] <= neg_q[comp_q] ? -unit_pos : unit_pos;
			end
			ST_DIST: begin
				if (step_q != 3'd0)
					acc_q <= acc_q + ACC_W'(prod);
			end
			default: ;
		endcase

		if (out_load) begin
			out_idx_q  <= idx_q;
			out_dist_q <= deg_q ? '0 : dist_sat;
			out_deg_q  <= deg_q;
		end
	end

	assign cfg_ready       = 1'b1;
	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign result_index    = out_idx_q;
	assign signed_distance = $signed(out_dist_q);
	assign degenerate_face = out_deg_q;

	`PPD_ASSERT_NOW(a_sqrt_owned, sqrt_sts.busy, state_q == ST_SQRT, "root unit busy outside root wait")
	`PPD_ASSERT_NOW(a_div_owned, div_sts.busy, state_q == ST_DIV, "divider busy outside divide wait")
	`PPD_ASSERT_NOW(a_dist_needs_normal, state_q == ST_DIST && step_q == 3'd3, normal_ready_q && !deg_q, "distance without a valid normal")
	`PPD_ASSERT_NEXT(a_deg_zero, out_load && deg_q, out_valid && degenerate_face && signed_distance == '0, "degenerate result not zero")

endmodule

### dv/point_plane_distance_tb.sv
`timescale 1ns / 100ps

module point_plane_distance_tb;
	import ppd_pkg::*;

	localparam int IDX_W = INDEX_BITS_DEF;
	localparam int C_MAX = (1 << (COORD_W - 1)) - 1;
	localparam int C_MIN = -(1 << (COORD_W - 1));
	localparam longint DIST_HI = (longint'(1) << (DIST_W - 1)) - 1;
	localparam longint DIST_LO = -(longint'(1) << (DIST_W - 1));
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [DIST_W-1:0] distance;
		logic degen;
	} dist_result_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VERTEX_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [IDX_W-1:0] point_index;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic out_valid;
	logic out_ready;
	logic [IDX_W-1:0] result_index;
	logic signed [DIST_W-1:0] signed_distance;
	logic degenerate_face;

	// face state mirrored from the register writes
	logic [VERTEX_W-1:0] face_a, face_b, face_c;
	logic signed [UNIT_W-1:0] unit_n [3];
	bit normal_cached;
	bit face_flat;

	dist_result_t expected_q[$];
	bit idle_on;
	int error_count;
	int points_sent;
	int results_seen;
	int normal_builds;
	int flat_builds;
	int writes_done;

	point_plane_distance #(
		.INDEX_BITS(IDX_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_index(point_index),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_index(result_index),
		.signed_distance(signed_distance),
		.degenerate_face(degenerate_face)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= !idle_on || ($urandom_range(99) >= 30);
	end

	initial begin
		#10_000_000;
		$display("** point_plane_distance: FAILED **");
		$finish;
	end

	function automatic longint vertex_coord(input logic [VERTEX_W-1:0] v, input int k);
		logic signed [COORD_W-1:0] c;
		c = v[k*COORD_W +: COORD_W];
		return c;
	endfunction

	function automatic logic [VERTEX_W-1:0] pack_vertex(input longint x, input longint y,
		input longint z);
		logic [COORD_W-1:0] cx, cy, cz;
		cx = COORD_W'(x);
		cy = COORD_W'(y);
		cz = COORD_W'(z);
		return {cz, cy, cx};
	endfunction

	function automatic point_t make_point(input int idx, input longint x, input longint y,
		input longint z);
		point_t p;
		p.idx = IDX_W'(idx);
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.z = COORD_W'(z);
		return p;
	endfunction

	function automatic int spread(input int half);
		return int'($urandom_range(0, 2 * half)) - half;
	endfunction

	function automatic int corner_coord();
		case ($urandom_range(3))
			0: return C_MAX;
			1: return C_MIN;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	// cross product, scale the magnitudes into [2^29, 2^30), root, divide
	function automatic void build_unit_normal();
		longint e1 [3], e2 [3], n [3];
		longint unsigned mag [3];
		longint unsigned peak, rem, root, bitv, q;
		logic [UNIT_W-1:0] u;
		bit neg [3];
		for (int k = 0; k < 3; k++) begin
			e1[k] = vertex_coord(face_b, k) - vertex_coord(face_a, k);
			e2[k] = vertex_coord(face_c, k) - vertex_coord(face_a, k);
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
		peak = 0;
		for (int k = 0; k < 3; k++) begin
			neg[k] = n[k] < 0;
			mag[k] = neg[k] ? -n[k] : n[k];
			if (mag[k] > peak) peak = mag[k];
		end
		normal_cached = 1;
		normal_builds++;
		if (peak == 0) begin
			face_flat = 1;
			flat_builds++;
			for (int k = 0; k < 3; k++) unit_n[k] = '0;
			return;
		end
		face_flat = 0;
		while (peak >= (64'd1 << 30)) begin
			for (int k = 0; k < 3; k++) mag[k] >>= 1;
			peak >>= 1;
		end
		while (peak < (64'd1 << 29)) begin
			for (int k = 0; k < 3; k++) mag[k] <<= 1;
			peak <<= 1;
		end
		rem = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		if (root == 0) root = 1;
		for (int k = 0; k < 3; k++) begin
			q = ((mag[k] << FRAC_SHIFT) + (root >> 1)) / root;
			u = UNIT_W'(q);
			unit_n[k] = neg[k] ? -u : u;
		end
	endfunction

	function automatic dist_result_t predict_distance(input point_t p);
		dist_result_t r;
		longint pc [3];
		longint acc, t;
		if (!normal_cached) build_unit_normal();
		r.idx = p.idx;
		if (face_flat) begin
			r.distance = '0;
			r.degen = 1'b1;
			return r;
		end
		pc[0] = longint'($signed(p.x));
		pc[1] = longint'($signed(p.y));
		pc[2] = longint'($signed(p.z));
		acc = 0;
		for (int k = 0; k < 3; k++)
			acc += longint'(unit_n[k]) * (pc[k] - vertex_coord(face_a, k));
		t = (acc + ROUND_HALF) >>> FRAC_SHIFT;
		if (t > DIST_HI) t = DIST_HI;
		if (t < DIST_LO) t = DIST_LO;
		r.distance = DIST_W'(t);
		r.degen = 1'b0;
		return r;
	endfunction

	task automatic report_error(input string msg);
		if (error_count < 40) $display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		dist_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_error($sformatf("result for index %0d with no request pending",
					result_index));
			end else begin
				want = expected_q.pop_front();
				results_seen++;
				if (result_index !== want.idx)
					report_error($sformatf("index %0d, expected %0d", result_index, want.idx));
				if (signed_distance !== want.distance)
					report_error($sformatf("index %0d: distance %0d, expected %0d",
						want.idx, signed_distance, $signed(want.distance)));
				if (degenerate_face !== want.degen)
					report_error($sformatf("index %0d: degenerate flag %0b, expected %0b",
						want.idx, degenerate_face, want.degen));
			end
		end
	end

	task automatic send_point(input point_t p);
		if (idle_on && $urandom_range(99) < 30) begin
			if (in_valid) in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		in_valid <= 1'b1;
		point_index <= p.idx;
		point_x <= p.x;
		point_y <= p.y;
		point_z <= p.z;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(predict_distance(p));
		points_sent++;
	endtask

	task automatic wait_drained();
		if (in_valid) in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after its last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VERTEX_W-1:0] val);
		bit hit;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		hit = 1;
		case (idx)
			REG_VERTEX_A: face_a = val;
			REG_VERTEX_B: face_b = val;
			REG_VERTEX_C: face_c = val;
			default: hit = 0;
		endcase
		if (hit) normal_cached = 0;
		writes_done++;
	endtask

	task automatic load_face(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
		input logic [VERTEX_W-1:0] c);
		write_reg(REG_VERTEX_A, a);
		write_reg(REG_VERTEX_B, b);
		write_reg(REG_VERTEX_C, c);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_face();
		send_point(make_point(0, 0, 0, 0));
		send_point(make_point(1023, C_MAX, C_MAX, C_MAX));
		send_point(make_point(341, C_MIN, C_MIN, C_MIN));
		wait_drained();
	endtask

	task automatic test_extreme_faces();
		load_face(pack_vertex(C_MIN, C_MIN, C_MIN), pack_vertex(C_MAX, C_MIN, C_MIN),
			pack_vertex(C_MIN, C_MAX, C_MIN));
		send_point(make_point(682, C_MAX, C_MAX, C_MAX));
		send_point(make_point(1, C_MIN, C_MIN, C_MIN));
		send_point(make_point(512, 0, 0, C_MAX));
		wait_drained();
		// swapped B and C: normal flips to -z
		load_face(pack_vertex(C_MAX, C_MAX, C_MAX), pack_vertex(C_MAX, C_MIN, C_MAX),
			pack_vertex(C_MIN, C_MAX, C_MAX));
		send_point(make_point(2, C_MIN, C_MIN, C_MIN));
		send_point(make_point(1022, C_MAX, C_MIN, 0));
		wait_drained();
		load_face(pack_vertex(C_MIN, 0, 0), pack_vertex(0, C_MAX, 0), pack_vertex(0, 0, C_MAX));
		send_point(make_point(3, C_MAX, C_MAX, C_MAX));
		send_point(make_point(4, C_MIN, C_MAX, C_MIN));
		wait_drained();
	endtask

	task automatic test_tiny_face();
		load_face(pack_vertex(0, 0, 0), pack_vertex(1, 0, 0), pack_vertex(0, 0, 1));
		send_point(make_point(5, 0, C_MAX, 0));
		send_point(make_point(6, 17, -1, 99));
		send_point(make_point(7, C_MIN, C_MIN, C_MAX));
		wait_drained();
	endtask

	task automatic test_flat_face();
		load_face(pack_vertex(100, 200, -300), pack_vertex(150, 190, -280),
			pack_vertex(250, 170, -240));
		send_point(make_point(8, 1000, -1000, 5));
		send_point(make_point(9, C_MAX, C_MIN, 0));
		wait_drained();
		write_reg(REG_VERTEX_C, pack_vertex(-7000, 3000, 90000));
		cfg_valid <= 1'b0;
		send_point(make_point(10, 1000, -1000, 5));
		send_point(make_point(11, C_MIN, C_MAX, C_MIN));
		wait_drained();
	endtask

	task automatic test_register_index();
		write_reg(REG_UNUSED, VERTEX_W'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
		send_point(make_point(12, -5000, 4000, 3000));
		send_point(make_point(13, 0, 0, 0));
		wait_drained();
		write_reg(REG_VERTEX_B, pack_vertex(C_MAX, -1, C_MIN));
		cfg_valid <= 1'b0;
		send_point(make_point(14, -5000, 4000, 3000));
		send_point(make_point(15, C_MAX, 0, C_MIN));
		wait_drained();
	endtask

	task automatic random_face();
		int kind, span, k;
		int ax, ay, az, dx, dy, dz;
		logic [CFG_IDX_W-1:0] r;
		kind = $urandom_range(9);
		if (kind < 4) begin
			load_face(VERTEX_W'({$urandom, $urandom}), VERTEX_W'({$urandom, $urandom}),
				VERTEX_W'({$urandom, $urandom}));
		end else if (kind < 7) begin
			span = 1 << $urandom_range(0, 12);
			ax = spread(1 << 18);
			ay = spread(1 << 18);
			az = spread(1 << 18);
			load_face(pack_vertex(ax, ay, az),
				pack_vertex(ax + spread(span), ay + spread(span), az + spread(span)),
				pack_vertex(ax + spread(span), ay + spread(span), az + spread(span)));
		end else if (kind == 7) begin
			ax = spread(1 << 17);
			ay = spread(1 << 17);
			az = spread(1 << 17);
			dx = spread(1 << 15);
			dy = spread(1 << 15);
			dz = spread(1 << 15);
			k = $urandom_range(0, 3);
			load_face(pack_vertex(ax, ay, az), pack_vertex(ax + dx, ay + dy, az + dz),
				pack_vertex(ax + k * dx, ay + k * dy, az + k * dz));
		end else if (kind == 8) begin
			r = CFG_IDX_W'($urandom_range(REG_VERTEX_A, REG_VERTEX_C));
			write_reg(r, VERTEX_W'({$urandom, $urandom}));
			cfg_valid <= 1'b0;
		end else begin
			write_reg(REG_UNUSED, VERTEX_W'({$urandom, $urandom}));
			cfg_valid <= 1'b0;
		end
	endtask

	function automatic point_t random_point();
		point_t p;
		int kind;
		p.idx = IDX_W'($urandom);
		kind = $urandom_range(9);
		if (kind < 6) begin
			p.x = COORD_W'($urandom);
			p.y = COORD_W'($urandom);
			p.z = COORD_W'($urandom);
		end else if (kind < 8) begin
			p.x = COORD_W'(vertex_coord(face_a, 0) + spread(4096));
			p.y = COORD_W'(vertex_coord(face_a, 1) + spread(4096));
			p.z = COORD_W'(vertex_coord(face_a, 2) + spread(4096));
		end else begin
			p.x = COORD_W'(corner_coord());
			p.y = COORD_W'(corner_coord());
			p.z = COORD_W'(corner_coord());
		end
		return p;
	endfunction

	task automatic test_random_phases();
		int n;
		for (int phase = 0; phase < 14; phase++) begin
			idle_on = (phase % 5) != 3;
			random_face();
			n = 48 + $urandom_range(32);
			for (int i = 0; i < n; i++) begin
				if (phase % 3 == 1 && i == n / 2) wait_drained();
				send_point(random_point());
			end
			wait_drained();
		end
		idle_on = 1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_VERTEX_A;
		cfg_data = '0;
		in_valid = 1'b0;
		point_index = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		out_ready = 1'b0;
		idle_on = 1;
		face_a = '0;
		face_b = '0;
		face_c = '0;
		for (int k = 0; k < 3; k++) unit_n[k] = '0;
		normal_cached = 0;
		face_flat = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_face();
		test_extreme_faces();
		test_tiny_face();
		test_flat_face();
		test_register_index();
		test_random_phases();

		wait_drained();
		repeat (40) @(posedge clk);
		$display("Sent %0d points, checked %0d results, %0d register writes.",
			points_sent, results_seen, writes_done);
		$display("Normal rebuilt %0d times, %0d of them on a flat face; %0d mismatches.",
			normal_builds, flat_builds, error_count);
		if (error_count == 0)
			$display("** point_plane_distance: PASSED **");
		else
			$display("** point_plane_distance: FAILED **");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ppd_pkg.sv
rtl/core/ppd_mul.sv
rtl/core/ppd_isqrt.sv
rtl/core/ppd_div.sv
rtl/core/point_plane_distance.sv
dv/point_plane_distance_tb.sv
